FILE: hdl/gtsd_pkg.sv
// Shared types and constants for the giant-tour split unit.
`default_nettype none
package gtsd_pkg;

  localparam int CoordWidth  = 16;
  localparam int DemandWidth = 16;
  localparam int SumWidth    = 32;
  localparam int PosWidth    = 10;
  localparam int OutCostWidth = 47;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 32;
  localparam int CoordSqWidth = 34;
  localparam int IntPairs    = 17;

  localparam logic [CfgIdxWidth-1:0] CFG_DEPOT_X  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DEPOT_Y  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_CAPACITY = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ROUND    = 2'd3;

  typedef struct packed {
    logic signed [CoordWidth-1:0] cust_x;
    logic signed [CoordWidth-1:0] cust_y;
    logic [DemandWidth-1:0]       cust_demand;
    logic                         last_customer;
  } gtsd_in_t;

  typedef struct packed {
    logic [PosWidth-1:0]     position;
    logic [PosWidth-1:0]     pred_position;
    logic [OutCostWidth-1:0] best_cost;
    logic                    infeasible;
    logic                    last_result;
  } gtsd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DD,
    ST_DD_WAIT,
    ST_DP,
    ST_DP_WAIT,
    ST_SUM1,
    ST_SUM2,
    ST_BK_RD,
    ST_BK_CHK,
    ST_PUSH,
    ST_CAP_RD,
    ST_CAP_CHK,
    ST_DOM_RD,
    ST_DOM_CHK,
    ST_COST1,
    ST_COST2
  } gtsd_state_t;

endpackage
`default_nettype wire

FILE: hdl/gtsd_dist.sv
// Euclidean distance: squares, then a bit-pair-per-cycle rounded square root.
`default_nettype none
module gtsd_dist
  import gtsd_pkg::*;
#(
  parameter int FRACTION_BITS = 8,
  parameter int COST_WIDTH    = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          round_mode,
  input  wire logic signed [CoordWidth-1:0]  ax,
  input  wire logic signed [CoordWidth-1:0]  ay,
  input  wire logic signed [CoordWidth-1:0]  bx,
  input  wire logic signed [CoordWidth-1:0]  by,
  output logic                               done,
  output logic [COST_WIDTH-1:0]              distance
);

  localparam int RW   = CoordSqWidth + 2 * FRACTION_BITS;
  localparam int RTW  = IntPairs + FRACTION_BITS + 1;
  localparam int RMW  = RTW + 2;
  localparam int MW   = (RTW > COST_WIDTH) ? RTW : COST_WIDTH;
  localparam int CNTW = $clog2(IntPairs + FRACTION_BITS + 1);
  localparam logic [CNTW-1:0] PAIRS_INT  = CNTW'(IntPairs);
  localparam logic [CNTW-1:0] PAIRS_FRAC = CNTW'(IntPairs + FRACTION_BITS);
  localparam logic [MW-1:0] CMAX = MW'({1'b0, {(COST_WIDTH-1){1'b1}}});

  logic signed [CoordWidth:0]     dx, dy;
  logic signed [2*CoordWidth+1:0] px, py;
  logic [CoordSqWidth-1:0]        sqx, sqy;
  logic [RW-1:0]                  rad;
  logic [RTW-1:0]                 root, root_next;
  logic [RMW-1:0]                 rem, rem_next;
  logic [RMW+1:0]                 rem_sh, trial;
  logic [CNTW-1:0]                cnt;
  logic                           prep, busy, rnd;
  logic [RTW-1:0]                 d_raw, d_scaled;

  assign dx = {ax[CoordWidth-1], ax} - {bx[CoordWidth-1], bx};
  assign dy = {ay[CoordWidth-1], ay} - {by[CoordWidth-1], by};
  assign px = dx * dx;
  assign py = dy * dy;

  always_comb begin
    rem_sh = {rem, rad[RW-1:RW-2]};
    trial  = (RMW+2)'({root, 2'b01});
    if (rem_sh >= trial) begin
      rem_next  = RMW'(rem_sh - trial);
      root_next = {root[RTW-2:0], 1'b1};
    end else begin
      rem_next  = RMW'(rem_sh);
      root_next = {root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sqx  <= CoordSqWidth'(px);
        sqy  <= CoordSqWidth'(py);
        rnd  <= round_mode;
        prep <= 1'b1;
      end else if (prep) begin
        rad  <= RW'(sqx + sqy) << (2 * FRACTION_BITS);
        root <= '0;
        rem  <= '0;
        cnt  <= rnd ? PAIRS_INT : PAIRS_FRAC;
        prep <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= rad << 2;
        root <= root_next;
        rem  <= rem_next;
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round to nearest: remainder above root means the true root is past root+1/2
  always_comb begin
    d_raw    = root + RTW'(RMW'(root) < rem);
    d_scaled = rnd ? (d_raw << FRACTION_BITS) : d_raw;
    if (MW'(d_scaled) > CMAX) distance = CMAX[COST_WIDTH-1:0];
    else distance = COST_WIDTH'(d_scaled);
  end

endmodule
`default_nettype wire

FILE: hdl/gtsd_deque_mem.sv
// Candidate deque storage: one write port, one registered read port.
`default_nettype none
module gtsd_deque_mem
  import gtsd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 90
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/giant_tour_split_dp_unit.sv
// Top level: split DP sequencer over the candidate deque memory.
//
// Customers of a giant tour enter on in_valid/in_ready in tour order, one
// transaction each; every customer yields one result on out_valid/out_ready:
// prefix length, best predecessor, prefix cost, an infeasible and a last flag.
// Configuration (depot, capacity, rounding) is to be written by the user via
// cfg_we/cfg_index/cfg_data only while the unit is idle; the unit itself does
// not enforce this. One item is processed at a time, and the unit turns ready
// for the next customer in the same cycle as the result turns valid. The shared
// square-root unit serves both distances and resolves one bit pair per cycle:
// 17 pairs with rounded distances, 17+FRACTION_BITS otherwise. Every back,
// capacity and dominance check of the deque is a read of the candidate memory.
// The first customer of a tour needs one distance only.
// A finished result sits in the output register, so the next customer is
// taken while the receiver stalls; a second result waits until it drains.
// Reset clears tour state, configuration (rounding on) and out_valid; the deque
// memory needs no clearing since an entry is read only after it is written.
// The tour ends on last_customer or at MAX_CUSTOMERS customers.
`default_nettype none
module giant_tour_split_dp_unit
  import gtsd_pkg::*;
#(
  parameter int MAX_CUSTOMERS = 1023,
  parameter int FRACTION_BITS = 8,
  parameter int COST_WIDTH    = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire gtsd_in_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output gtsd_out_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data
);

  localparam int CW = COST_WIDTH;
  localparam int DQ = MAX_CUSTOMERS + 1;
  localparam int AW = $clog2(DQ);
  localparam int PW = $clog2(MAX_CUSTOMERS + 1);
  localparam int EW = PW + CW + SumWidth;
  localparam logic signed [CW-1:0] CMAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   CMAX_X = {2'b00, {(CW-1){1'b1}}};
  localparam logic [63:0] OUT_MAX = {17'd0, {OutCostWidth{1'b1}}};

  // configuration
  logic signed [CoordWidth-1:0] depot_x, depot_y;
  logic [SumWidth-1:0]          capacity;
  logic                         round_dist;

  // tour state
  logic [AW-1:0]          head;
  logic [AW:0]            count;
  logic [SumWidth-1:0]    run_dem;
  logic signed [CW-1:0]   run_dist;
  logic signed [CoordWidth-1:0] prev_x, prev_y;
  logic signed [CW-1:0]   pending;
  logic [PW-1:0]          tour_pos;

  // per-item working registers
  gtsd_in_t               cur;
  logic signed [CW-1:0]   dd, dp, newdist, part, score, c1;
  logic [SumWidth-1:0]    newdem;
  logic [PW-1:0]          hd_pos;
  logic signed [CW-1:0]   hd_score;

  gtsd_state_t state, state_next;

  // memory and distance unit hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic [PW-1:0]          rd_pos;
  logic signed [CW-1:0]   rd_score;
  logic [SumWidth-1:0]    rd_dsum;
  logic                   dist_start, dist_done;
  logic signed [CoordWidth-1:0] dist_ax, dist_ay;
  logic [CW-1:0]          dist_val;

  // finishing values
  logic signed [CW-1:0]   c2, cost_fin;
  logic [63:0]            cost_u;
  logic                   fin_infeasible, fin_last, fin_go;
  logic                   back_pop, cap_pop, dom_pop;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s > CMAX_X) sat_add = CMAX;
    else if (s < -CMAX_X) sat_add = -CMAX;
    else sat_add = CW'(s);
  endfunction

  function automatic logic [AW-1:0] dq_at(input logic [AW-1:0] base, input logic [AW:0] off);
    logic [AW+1:0] s;
    s = (AW+2)'(base) + (AW+2)'(off);
    if (s >= (AW+2)'(DQ)) s = s - (AW+2)'(DQ);
    dq_at = AW'(s);
  endfunction

  gtsd_dist #(
    .FRACTION_BITS(FRACTION_BITS),
    .COST_WIDTH(COST_WIDTH)
  ) u_dist (
    .clk(clk),
    .rst(rst),
    .start(dist_start),
    .round_mode(round_dist),
    .ax(dist_ax),
    .ay(dist_ay),
    .bx(cur.cust_x),
    .by(cur.cust_y),
    .done(dist_done),
    .distance(dist_val)
  );

  gtsd_deque_mem #(
    .DEPTH(DQ),
    .AW(AW),
    .DW(EW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_pos   = mem_rdata[EW-1 -: PW];
  assign rd_score = $signed(mem_rdata[CW+SumWidth-1 -: CW]);
  assign rd_dsum  = mem_rdata[SumWidth-1:0];

  assign back_pop = (rd_score >= score);
  assign cap_pop  = ((newdem - rd_dsum) > capacity);
  assign dom_pop  = (hd_score >= rd_score);

  always_comb begin
    c2       = sat_add(c1, dd);
    cost_fin = (count == '0) ? CMAX : ((c2 < 0) ? '0 : c2);
    fin_infeasible = (count == '0) || (cost_fin >= CMAX);
    cost_u   = 64'($unsigned(cost_fin));
    fin_last = cur.last_customer ||
               (((PW+1)'(tour_pos) + 1'b1) >= (PW+1)'(MAX_CUSTOMERS));
    fin_go   = (state == ST_COST2) && (!out_valid || out_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_DD;
      ST_DD:      state_next = ST_DD_WAIT;
      ST_DD_WAIT: if (dist_done) state_next = (tour_pos == '0) ? ST_SUM1 : ST_DP;
      ST_DP:      state_next = ST_DP_WAIT;
      ST_DP_WAIT: if (dist_done) state_next = ST_SUM1;
      ST_SUM1:    state_next = ST_SUM2;
      ST_SUM2:    state_next = (tour_pos != '0 && count != '0) ? ST_BK_RD : ST_PUSH;
      ST_BK_RD:   state_next = ST_BK_CHK;
      ST_BK_CHK:  state_next = (back_pop && count > (AW+1)'(1)) ? ST_BK_RD : ST_PUSH;
      ST_PUSH:    state_next = ST_CAP_RD;
      ST_CAP_RD:  state_next = ST_CAP_CHK;
      ST_CAP_CHK: begin
        if (cap_pop) state_next = (count > (AW+1)'(1)) ? ST_CAP_RD : ST_COST1;
        else state_next = (count >= (AW+1)'(2)) ? ST_DOM_RD : ST_COST1;
      end
      ST_DOM_RD:  state_next = ST_DOM_CHK;
      ST_DOM_CHK: state_next = (dom_pop && count > (AW+1)'(2)) ? ST_DOM_RD : ST_COST1;
      ST_COST1:   state_next = ST_COST2;
      ST_COST2:   if (fin_go) state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    dist_start = (state == ST_DD) || (state == ST_DP);
    dist_ax    = (state == ST_DP) ? prev_x : depot_x;
    dist_ay    = (state == ST_DP) ? prev_y : depot_y;
    mem_we     = (state == ST_PUSH);
    mem_waddr  = dq_at(head, count);
    mem_wdata  = {tour_pos, score, run_dem};
    unique case (state)
      ST_BK_RD:  mem_raddr = dq_at(head, count - 1'b1);
      ST_DOM_RD: mem_raddr = dq_at(head, (AW+1)'(1));
      default:   mem_raddr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depot_x    <= '0;
      depot_y    <= '0;
      capacity   <= '0;
      round_dist <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPOT_X:  depot_x    <= $signed(cfg_data[CoordWidth-1:0]);
        CFG_DEPOT_Y:  depot_y    <= $signed(cfg_data[CoordWidth-1:0]);
        CFG_CAPACITY: capacity   <= cfg_data[SumWidth-1:0];
        CFG_ROUND:    round_dist <= cfg_data[0];
      endcase
    end
  end

  // datapath and tour state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= (AW+1)'(1);
      run_dem  <= '0;
      run_dist <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      pending  <= '0;
      tour_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !fin_go) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) cur <= in_data;
        ST_DD_WAIT: begin
          if (dist_done) begin
            dd <= $signed(dist_val);
            dp <= '0;
          end
        end
        ST_DP_WAIT: if (dist_done) dp <= $signed(dist_val);
        ST_SUM1: begin
          newdist <= sat_add(run_dist, dp);
          part    <= sat_add(pending, dd);
          newdem  <= ((SumWidth+1)'(run_dem) + (SumWidth+1)'(cur.cust_demand)) >
                     (SumWidth+1)'({SumWidth{1'b1}}) ? '1 :
                     run_dem + SumWidth'(cur.cust_demand);
        end
        ST_SUM2: begin
          score <= sat_add(part, -newdist);
          if (tour_pos == '0) begin
            head  <= '0;
            count <= '0;
          end
        end
        ST_BK_CHK: if (back_pop) count <= count - 1'b1;
        ST_PUSH:   count <= count + 1'b1;
        ST_CAP_CHK: begin
          if (cap_pop) begin
            head  <= dq_at(head, (AW+1)'(1));
            count <= count - 1'b1;
          end else begin
            hd_pos   <= rd_pos;
            hd_score <= rd_score;
          end
        end
        ST_DOM_CHK: begin
          if (dom_pop) begin
            head     <= dq_at(head, (AW+1)'(1));
            count    <= count - 1'b1;
            hd_pos   <= rd_pos;
            hd_score <= rd_score;
          end
        end
        ST_COST1: c1 <= sat_add(hd_score, newdist);
        ST_COST2: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            out_data.position      <= PosWidth'((PW+1)'(tour_pos) + 1'b1);
            out_data.pred_position <= (count == '0) ? '0 : PosWidth'(hd_pos);
            out_data.best_cost     <= (cost_u > OUT_MAX) ? '1 : OutCostWidth'(cost_u);
            out_data.infeasible    <= fin_infeasible;
            out_data.last_result   <= fin_last;
            if (fin_last) begin
              head     <= '0;
              count    <= (AW+1)'(1);
              run_dem  <= '0;
              run_dist <= '0;
              prev_x   <= '0;
              prev_y   <= '0;
              pending  <= '0;
              tour_pos <= '0;
            end else begin
              run_dem  <= newdem;
              run_dist <= newdist;
              prev_x   <= cur.cust_x;
              prev_y   <= cur.cust_y;
              pending  <= cost_fin;
              tour_pos <= tour_pos + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DQ))
    else $error("deque count exceeds depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (count < (AW+1)'(DQ)))
    else $error("push into full deque");

  a_dist_done_wait: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == ST_DD_WAIT || state == ST_DP_WAIT))
    else $error("distance result outside wait state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COST2 && out_valid && !out_ready) |=> (state == ST_COST2))
    else $error("result overwrote a pending output");

endmodule
`default_nettype wire

FILE: tb/tour_split_checker.sv
// Watches the split unit channels, predicts each result and compares it.
module tour_split_checker
  import gtsd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire gtsd_in_t                in_data,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire gtsd_out_t               out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data,
  output int                           pending,
  output int                           mismatches
);

  localparam int     TourMax  = 1023;
  localparam int     DqDepth  = 1024;
  localparam int     FracBits = 8;
  localparam int     ExpDepth = 64;
  localparam longint CostMax  = (64'sd1 <<< 47) - 1;

  // configuration copy
  longint depot_x, depot_y, capacity;
  bit     round_on;

  // tour state copy
  int     cand_pos [DqDepth];
  longint cand_score [DqDepth];
  longint cand_dem [DqDepth];
  int     head, count, tour_len;
  longint run_dem, run_dist, prev_x, prev_y, prefix_cost;

  // expected results in order, ring indexed by running write/read counts
  gtsd_out_t expected_splits [ExpDepth];
  int        exp_wr = 0;
  int        exp_rd = 0;

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > CostMax - b) return CostMax;
    if (b < 0 && a < -CostMax - b) return -CostMax;
    return a + b;
  endfunction

  // nearest integer to sqrt(s * 4^f)
  function automatic longint root_nearest(longint s, int f);
    longint root, rem, pair, trial;
    root = 0;
    rem = 0;
    for (int q = 16 + f; q >= 0; q--) begin
      pair = (q >= f) ? ((s >> (2 * (q - f))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root++;
    return root;
  endfunction

  function automatic longint leg_len(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy, d;
    dx = x1 - x2;
    dy = y1 - y2;
    if (round_on) d = root_nearest(dx * dx + dy * dy, 0) << FracBits;
    else d = root_nearest(dx * dx + dy * dy, FracBits);
    return (d > CostMax) ? CostMax : d;
  endfunction

  function automatic int slot(int k);
    return (head + k) % DqDepth;
  endfunction

  function automatic void clear_tour();
    head = 0;
    count = 1;
    tour_len = 0;
    run_dem = 0;
    run_dist = 0;
    prev_x = 0;
    prev_y = 0;
    prefix_cost = 0;
  endfunction

  function automatic gtsd_out_t predict_split(gtsd_in_t c);
    gtsd_out_t r;
    longint cx, cy, dd, dp, new_dist, score, new_dem, cost;
    int     pred, t;
    bit     bad, last;
    cx = longint'(c.cust_x);
    cy = longint'(c.cust_y);
    last = c.last_customer;
    dd = leg_len(depot_x, depot_y, cx, cy);
    dp = (tour_len == 0) ? 0 : leg_len(prev_x, prev_y, cx, cy);
    new_dist = sat_add(run_dist, dp);
    score = sat_add(sat_add(prefix_cost, dd), -new_dist);
    pred = 0;
    if (tour_len == 0) begin
      head = 0;
      count = 0;
    end else begin
      while (count > 0 && cand_score[slot(count - 1)] >= score) count--;
    end
    t = slot(count);
    cand_pos[t] = tour_len;
    cand_score[t] = score;
    cand_dem[t] = run_dem;
    count++;
    new_dem = run_dem + c.cust_demand;
    if (new_dem > 64'hFFFF_FFFF) new_dem = 64'hFFFF_FFFF;
    while (count > 0 && new_dem - cand_dem[head] > capacity) begin
      head = slot(1);
      count--;
    end
    while (count >= 2 && cand_score[head] >= cand_score[slot(1)]) begin
      head = slot(1);
      count--;
    end
    if (count == 0) begin
      cost = CostMax;
      bad = 1;
    end else begin
      pred = cand_pos[head];
      cost = sat_add(sat_add(cand_score[head], new_dist), dd);
      if (cost < 0) cost = 0;
      bad = (cost >= CostMax);
    end
    if (tour_len + 1 >= TourMax) last = 1;
    r.position = PosWidth'(tour_len + 1);
    r.pred_position = PosWidth'(pred);
    r.best_cost = OutCostWidth'(cost);
    r.infeasible = bad;
    r.last_result = last;
    if (last) begin
      clear_tour();
    end else begin
      run_dem = new_dem;
      run_dist = new_dist;
      prev_x = cx;
      prev_y = cy;
      prefix_cost = cost;
      tour_len++;
    end
    return r;
  endfunction

  initial mismatches = 0;
  initial pending = 0;

  always @(posedge clk) begin
    gtsd_out_t want;
    if (rst) begin
      depot_x = 0;
      depot_y = 0;
      capacity = 0;
      round_on = 1;
      clear_tour();
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result transaction: %p", out_data);
        end else begin
          want = expected_splits[exp_rd % ExpDepth];
          exp_rd++;
          if (want.position !== out_data.position ||
              want.pred_position !== out_data.pred_position ||
              want.best_cost !== out_data.best_cost ||
              want.infeasible !== out_data.infeasible ||
              want.last_result !== out_data.last_result) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_splits[exp_wr % ExpDepth] = predict_split(in_data);
        exp_wr++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPOT_X:  depot_x = longint'($signed(cfg_data[15:0]));
          CFG_DEPOT_Y:  depot_y = longint'($signed(cfg_data[15:0]));
          CFG_CAPACITY: capacity = longint'(cfg_data);
          CFG_ROUND:    round_on = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= exp_wr - exp_rd;
  end

endmodule

FILE: tb/giant_tour_split_dp_unit_test.sv
// Stimulus and verdict for the giant-tour split unit.
module giant_tour_split_dp_unit_test;
  import gtsd_pkg::*;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    in_valid = 0;
  logic                    in_ready;
  gtsd_in_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 0;
  gtsd_out_t               out_data;
  logic                    cfg_we = 0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  int                      pending;
  int                      mismatches;

  int burst_left = 0;
  int items_sent = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int cx_base, cy_base, spread, dem_max;
  bit long_done = 0;

  giant_tour_split_dp_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tour_split_checker split_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: stall pattern that changes mode, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= 400;
      out_ready <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  task automatic send(input gtsd_in_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic customer(input int x, input int y, input int dem, input bit last);
    gtsd_in_t d;
    d.cust_x = x[15:0];
    d.cust_y = y[15:0];
    d.cust_demand = dem[15:0];
    d.last_customer = last;
    send(d);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input int dx, input int dy, input logic [31:0] cap,
                            input bit rnd);
    cfg_we <= 1;
    cfg_index <= CFG_DEPOT_X;
    cfg_data <= dx;
    @(posedge clk);
    cfg_index <= CFG_DEPOT_Y;
    cfg_data <= dy;
    @(posedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_data <= cap;
    @(posedge clk);
    cfg_index <= CFG_ROUND;
    cfg_data <= {31'd0, rnd};
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic int coord(input int base);
    int v;
    case ($urandom_range(0, 9))
      0: v = -32768;
      1: v = 32767;
      2: v = $urandom_range(0, 65535) - 32768;
      default: v = base + $urandom_range(0, 2 * spread) - spread;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int demand();
    case ($urandom_range(0, 9))
      0: return 65535;
      1: return 0;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, dem_max);
    endcase
  endfunction

  task automatic random_tour(input int len, input bit flag_end);
    for (int i = 0; i < len; i++)
      customer(coord(cx_base), coord(cy_base), demand(),
               flag_end && (i == len - 1));
  endtask

  initial begin
    logic [31:0] cap;
    int len;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: zero capacity, only zero-demand customers fit
    customer(0, 0, 0, 0);
    customer(5, 7, 1, 0);
    customer(-32768, -32768, 0, 0);
    customer(32767, 32767, 0, 1);
    customer(3, 4, 1, 1);
    drain();

    set_config(-32768, 32767, 32'hFFFF_FFFF, 0);
    customer(32767, -32768, 65535, 0);
    customer(-32768, 32767, 65535, 0);
    customer(0, 0, 0, 0);
    customer(1, 1, 100, 1);
    drain();

    // receiver holds off while this tour keeps coming, so the unit backs up
    set_config(32767, -32768, 32'd100, 1);
    hold_asks++;
    customer(10, 10, 60, 0);
    customer(20, 10, 50, 0);
    customer(20, 20, 40, 0);
    customer(10, 20, 101, 0);
    customer(15, 15, 30, 0);
    customer(15, 16, 100, 1);
    drain();

    set_config(0, 0, 32'd0, 0);
    customer(1, 0, 0, 0);
    customer(1, 1, 0, 0);
    customer(0, 1, 1, 1);
    drain();

    while (items_sent < 1900) begin
      case ($urandom_range(0, 5))
        0: cap = 32'd0;
        1: cap = 32'hFFFF_FFFF;
        2: cap = $urandom;
        default: cap = $urandom_range(50, 3000);
      endcase
      dem_max = (cap > 32'd262140) ? 65535 : cap / 4 + 1;
      case ($urandom_range(0, 4))
        0: set_config(-32768, -32768, cap, $urandom_range(0, 1));
        1: set_config(32767, 32767, cap, $urandom_range(0, 1));
        default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535), cap,
                            $urandom_range(0, 1));
      endcase
      cx_base = $urandom_range(0, 60000) - 30000;
      cy_base = $urandom_range(0, 60000) - 30000;
      spread = ($urandom_range(0, 1) == 0) ? 50 : 2000;
      if (!long_done && items_sent > 600) begin
        // runs past the tour length limit without marking an end
        long_done = 1;
        random_tour(1030, 0);
        customer(0, 0, 0, 1);
      end else begin
        for (int t = $urandom_range(1, 5); t > 0; t--) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200)
                                            : $urandom_range(1, 30);
          if ($urandom_range(0, 3) == 0) hold_asks++;
          random_tour(len, 1);
        end
      end
      drain();
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
